/* rtl/hmle_pkg.sv */
// Package for the HDR linear exposure merge block.
// Holds shared types, fixed-point constants and the per-channel weight/log helpers.
// No dependencies.
package hmle_pkg;

    localparam int DEFAULT_MAX_EXPOSURES = 4;

    localparam int SAMPLE_W  = 16;
    localparam int LANES     = 3;
    localparam int IDX_W     = 2;
    localparam int OFF_W     = 24;
    localparam int OUT_W     = 24;
    localparam int WEIGHT_W  = 17;
    localparam int SUM_W     = 48;
    localparam int WSUM_W    = 20;
    localparam int FRAC_W    = 20;
    localparam int LN_W      = 21;
    localparam int TERM_W    = 44;
    localparam int QUOT_W    = 23;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [SAMPLE_W-1:0] LOW_KNEE  = 16'd13107;
    localparam logic [SAMPLE_W-1:0] HIGH_KNEE = 16'd52428;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd65535;
    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [31:0]         LN2_Q32   = 32'd2977044472;

    localparam logic [CNT_W-1:0] SQR_LAST = CNT_W'(FRAC_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DARKEST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHTEST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_3 = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_LNMUL,
        ST_TERM,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]            darkest;
        logic [IDX_W-1:0]            lightest;
        logic [3:0][OFF_W-1:0]       log_offset;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic sqr;
        logic lnmul;
        logic term;
        logic acc;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

    // Hat weight, Q1.16. 65536/13107 = 5 + 1/13107, so the ramps are exactly 5*v.
    function automatic logic [WEIGHT_W-1:0] hat_weight(
        input logic [SAMPLE_W-1:0] v,
        input logic                skip_low,
        input logic                skip_high
    );
        logic [WEIGHT_W-1:0] x;
        logic [WEIGHT_W-1:0] res;
        x   = {1'b0, v};
        res = ONE_Q16;
        if (v < LOW_KNEE) begin
            if (!skip_low) res = (x << 2) + x;
        end else if (v > HIGH_KNEE) begin
            if (!skip_high) begin
                x   = {1'b0, FULL_SCALE - v};
                res = (x << 2) + x;
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] msb_pos(input logic [SAMPLE_W-1:0] v);
        logic [3:0] e;
        e = 4'd0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (v[i]) e = 4'(i);
        end
        return e;
    endfunction

endpackage

/* rtl/hmle_cfg.sv */
// Configuration register file of the HDR merge block.
// Depends on hmle_pkg.
module hmle_cfg import hmle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [OFF_W-1:0]     i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.darkest    <= IDX_W'(0);
            r_cfg.lightest   <= IDX_W'(1);
            r_cfg.log_offset <= '0;
        end else if (i_wr_en) begin
            case (i_index)
                CFG_DARKEST:  r_cfg.darkest       <= i_wr_data[IDX_W-1:0];
                CFG_LIGHTEST: r_cfg.lightest      <= i_wr_data[IDX_W-1:0];
                CFG_OFFSET_0: r_cfg.log_offset[0] <= i_wr_data;
                CFG_OFFSET_1: r_cfg.log_offset[1] <= i_wr_data;
                CFG_OFFSET_2: r_cfg.log_offset[2] <= i_wr_data;
                CFG_OFFSET_3: r_cfg.log_offset[3] <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/hmle_dp.sv */
// Datapath: hat weights, iterative ln per channel, weighted accumulation and
// restoring divider for the means. Depends on hmle_pkg.
module hmle_dp import hmle_pkg::*; #(
    parameter int MAX_EXPOSURES = DEFAULT_MAX_EXPOSURES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  t_cfg                        i_cfg,
    input  logic [LANES*SAMPLE_W-1:0]   i_samples,
    input  logic [IDX_W-1:0]            i_index,
    input  logic                        i_last,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [LANES*OUT_W-1:0]      o_out_data
);

    logic [LANES-1:0][WEIGHT_W-1:0] r_w;
    logic [LANES-1:0][3:0]          r_e;
    logic [LANES-1:0]               r_small;
    logic [LANES-1:0][31:0]         r_m;
    logic [LANES-1:0][FRAC_W-1:0]   r_frac;
    logic [LANES-1:0][LN_W-1:0]     r_ln;
    logic [LANES-1:0][TERM_W-1:0]   r_term;
    logic [LANES-1:0][SUM_W-1:0]    r_sum;
    logic [LANES-1:0]               r_neg;
    logic [LANES-1:0]               r_sat;
    logic [LANES-1:0][SUM_W:0]      r_rem;
    logic [LANES-1:0][QUOT_W-1:0]   r_q;
    logic [SUM_W:0]                 r_dv;
    logic                           r_wzero;
    logic [WEIGHT_W-1:0]            r_p1;
    logic [WEIGHT_W-1:0]            r_p;
    logic [WSUM_W-1:0]              r_wsum;
    logic [OFF_W-1:0]               r_off;
    logic                           r_valid;
    logic                           r_last;
    logic                           r_out_valid;
    logic [LANES*OUT_W-1:0]         r_out_data;

    logic skip_low, skip_high;
    assign skip_low  = (i_index == i_cfg.lightest);
    assign skip_high = (i_index == i_cfg.darkest);

    // pixel weight, recomputed every cycle from the held channel weights
    logic [2*WEIGHT_W-1:0] pm1, pm2;
    assign pm1 = (2*WEIGHT_W)'(r_w[0]) * (2*WEIGHT_W)'(r_w[1]);
    assign pm2 = (2*WEIGHT_W)'(r_p1) * (2*WEIGHT_W)'(r_w[2]);

    always_ff @(posedge i_clk) begin
        r_p1 <= pm1[16 +: WEIGHT_W];
        r_p  <= pm2[16 +: WEIGHT_W] + WEIGHT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] v;
        logic [3:0]          e;
        logic [SAMPLE_W-1:0] vn;
        logic [63:0]         sq;
        logic [32:0]         t;
        logic [56:0]         lp;
        logic signed [25:0]  diff;
        logic [SUM_W-1:0]    mag;
        logic [SUM_W:0]      dd;
        logic [SUM_W:0]      lim;
        for (int c = 0; c < LANES; c++) begin
            if (i_cmd.load) begin
                v  = i_samples[c*SAMPLE_W +: SAMPLE_W];
                e  = msb_pos(v);
                vn = v << (4'd15 - e);
                r_w[c]     <= hat_weight(v, skip_low, skip_high);
                r_e[c]     <= e;
                r_small[c] <= (v < SAMPLE_W'(2));
                r_m[c]     <= {vn, 16'h0000};
                r_frac[c]  <= '0;
            end
            if (i_cmd.sqr) begin
                sq = 64'(r_m[c]) * 64'(r_m[c]);
                t  = sq[63:31];
                r_frac[c] <= {r_frac[c][FRAC_W-2:0], t[32]};
                r_m[c]    <= t[32] ? t[32:1] : t[31:0];
            end
            if (i_cmd.lnmul) begin
                lp = 57'({r_e[c], r_frac[c]}) * 57'(LN2_Q32) + (57'd1 << 35);
                r_ln[c] <= r_small[c] ? '0 : lp[56:36];
            end
            if (i_cmd.term) begin
                diff = $signed({5'b0, r_ln[c]}) - $signed({{2{r_off[OFF_W-1]}}, r_off});
                r_term[c] <= $signed({1'b0, r_p}) * diff;
            end
            if (i_cmd.div_init) begin
                mag = r_sum[c][SUM_W-1] ? (~r_sum[c] + SUM_W'(1)) : r_sum[c];
                dd  = {1'b0, mag} + (SUM_W+1)'(r_wsum >> 1);
                lim = (SUM_W+1)'(r_wsum) << QUOT_W;
                r_neg[c] <= r_sum[c][SUM_W-1];
                r_sat[c] <= (dd >= lim);
                r_rem[c] <= dd;
                r_q[c]   <= '0;
            end
            if (i_cmd.div_step) begin
                if (r_rem[c] >= r_dv) begin
                    r_rem[c] <= r_rem[c] - r_dv;
                    r_q[c]   <= {r_q[c][QUOT_W-2:0], 1'b1};
                end else begin
                    r_q[c]   <= {r_q[c][QUOT_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.load) begin
            r_off   <= i_cfg.log_offset[i_index];
            r_valid <= ({1'b0, i_index} < 3'(MAX_EXPOSURES));
            r_last  <= i_last;
        end
        if (i_cmd.div_init) begin
            r_dv    <= (SUM_W+1)'(r_wsum) << (QUOT_W - 1);
            r_wzero <= (r_wsum == '0);
        end else if (i_cmd.div_step) begin
            r_dv <= r_dv >> 1;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        logic [SUM_W:0]  s;
        logic [WSUM_W:0] ws;
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_wsum <= '0;
        end else if (i_cmd.out_load) begin
            r_sum  <= '0;
            r_wsum <= '0;
        end else if (i_cmd.acc && r_valid) begin
            for (int c = 0; c < LANES; c++) begin
                s = {r_sum[c][SUM_W-1], r_sum[c]}
                    + {{(SUM_W+1-TERM_W){r_term[c][TERM_W-1]}}, r_term[c]};
                if (s[SUM_W] != s[SUM_W-1])
                    r_sum[c] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
                else
                    r_sum[c] <= s[SUM_W-1:0];
            end
            ws = (WSUM_W+1)'(r_wsum) + (WSUM_W+1)'(r_p);
            r_wsum <= ws[WSUM_W] ? {WSUM_W{1'b1}} : ws[WSUM_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int c = 0; c < LANES; c++) begin
                if (r_wzero)
                    r_out_data[c*OUT_W +: OUT_W] <= '0;
                else if (r_sat[c])
                    r_out_data[c*OUT_W +: OUT_W] <= r_neg[c] ? 24'h800000 : 24'h7FFFFF;
                else if (r_neg[c])
                    r_out_data[c*OUT_W +: OUT_W] <= ~{1'b0, r_q[c]} + OUT_W'(1);
                else
                    r_out_data[c*OUT_W +: OUT_W] <= {1'b0, r_q[c]};
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/hmle_ctrl.sv */
// Sequencing controller of the HDR merge block: steps the ln, accumulate and
// divide phases of the datapath. Depends on hmle_pkg.
module hmle_ctrl import hmle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == SQR_LAST) n_state = ST_LNMUL;
            end
            ST_LNMUL: begin
                o_cmd.lnmul = 1'b1;
                n_state     = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/hdr_merge_linear_exposures_top.sv */
// Top level of the HDR linear exposure merge block.
// Depends on hmle_pkg, hmle_cfg, hmle_ctrl and hmle_dp.
//
// Usage:
//   Slave channel: one transaction per exposure of a pixel, RGB samples in tdata,
//   exposure index in tuser, tlast on the final exposure of the pixel.
//   Master channel: one transaction per pixel with the three weighted mean log
//   radiances, signed Q8.16.
//   Config port: write enable, register index, data; write only while idle.
// Sequence: an exposure is accepted, then passes through 20 squaring steps of the
//   per-channel ln unit, log multiply, term multiply and accumulate; no new exposure
//   is taken before the block is idle again. A last exposure goes on to divider set-up,
//   the 23-step restoring divider and the output load, which raises m_axis_tvalid.
// Reset clears the accumulators, the controller and the output valid flag;
//   configuration returns to darkest 0, lightest 1, offsets 0.
// A stalled receiver holds the result in the output register; the block keeps
//   taking exposures of the next pixel and waits only when a second result is ready.
module hdr_merge_linear_exposures_top import hmle_pkg::*; #(
    parameter int MAX_EXPOSURES = DEFAULT_MAX_EXPOSURES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [LANES*SAMPLE_W-1:0] s_axis_tdata,  // red, green, blue sample
    input  logic [IDX_W-1:0]          s_axis_tuser,  // exposure index
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [LANES*OUT_W-1:0]    m_axis_tdata,  // red, green, blue log radiance
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [OFF_W-1:0]          i_cfg_wr_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    hmle_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_index   (i_cfg_index),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (cfg)
    );

    hmle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hmle_dp #(
        .MAX_EXPOSURES (MAX_EXPOSURES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg       (cfg),
        .i_samples   (s_axis_tdata),
        .i_index     (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
